>>> rtl/core/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg: shared types and codes for the circular deque
// Request action codes, result status codes, fixed field widths and the
// command group that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package cdq_pkg;

  // fixed field widths
  localparam int ACT_W  = 2;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;
  localparam int CAP_W  = 5;

  typedef logic [ACT_W-1:0]  action_t;
  typedef logic [STAT_W-1:0] status_t;

  // request actions
  localparam action_t ACT_PUSH_REAR  = 2'd0;
  localparam action_t ACT_PUSH_FRONT = 2'd1;
  localparam action_t ACT_POP_FRONT  = 2'd2;
  localparam action_t ACT_POP_REAR   = 2'd3;

  // result status
  localparam status_t STAT_OK    = 2'd0;
  localparam status_t STAT_FULL  = 2'd1;
  localparam status_t STAT_EMPTY = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic exec;  // run the accepted request, issue the store read
    logic load;  // move the finished result into the output register
  } cdq_cmd_t;

endpackage

>>> rtl/core/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl: request sequencer for the circular deque
// Two-state machine: take a request, then wait for the registered store
// read and hand the result to the output register when it is free.
// ----------------------------------------------------------------------------
module cdq_ctrl import cdq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output cdq_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;
  logic out_free;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign cmd.exec = accept;
  assign cmd.load = (state_r == S_READ) && out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_READ;
      end
      S_READ: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output register occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/core/cdq_datapath.sv
// ----------------------------------------------------------------------------
// cdq_datapath: storage and pointer logic for the circular deque
// Holds the entry store, head/tail indices, held count and capacity, and
// the output result register.
// ----------------------------------------------------------------------------
module cdq_datapath import cdq_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cdq_cmd_t                     cmd,
  input  action_t                      action,
  input  logic signed [DATA_WIDTH-1:0] data_in,
  input  logic                         cfg_wr_en,
  input  logic [CAP_W-1:0]             cfg_wr_data,
  output logic signed [DATA_WIDTH-1:0] data_out,
  output status_t                      status,
  output logic [OCC_W-1:0]             occupancy
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] cap_r, cap_nxt;

  logic [DATA_WIDTH-1:0] rd_data_r;
  status_t               pend_stat_r, pend_stat_nxt;
  logic                  pend_pop_r, pend_pop_nxt;

  logic signed [DATA_WIDTH-1:0] out_data_r;
  status_t                      out_stat_r;
  logic [OCC_W-1:0]             out_occ_r;

  logic          wr_en, rd_en;
  logic [IW-1:0] waddr, raddr;
  logic [IW-1:0] cap_m1;
  logic [IW-1:0] tail_inc, tail_dec, head_inc, head_dec;
  logic          is_full, is_empty, last_one;
  logic [CW-1:0] cfg_cap;

  // index wrap helpers
  assign cap_m1   = IW'(cap_r - 1'b1);
  assign tail_inc = (tail_r == cap_m1) ? '0 : tail_r + 1'b1;
  assign tail_dec = (tail_r == '0) ? cap_m1 : tail_r - 1'b1;
  assign head_inc = (head_r == cap_m1) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? cap_m1 : head_r - 1'b1;

  assign is_full  = (count_r == cap_r);
  assign is_empty = (count_r == '0);
  assign last_one = (count_r == CW'(1));

  // capacity clamp: zero acts as one, above DEPTH acts as DEPTH
  always_comb begin
    if (cfg_wr_data == '0) begin
      cfg_cap = CW'(1);
    end else if (32'(cfg_wr_data) > DEPTH) begin
      cfg_cap = CW'(DEPTH);
    end else begin
      cfg_cap = CW'(cfg_wr_data);
    end
  end

  // request execution
  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    cap_nxt       = cap_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    waddr         = '0;
    raddr         = head_r;
    pend_stat_nxt = pend_stat_r;
    pend_pop_nxt  = pend_pop_r;

    if (cfg_wr_en) begin
      // new capacity empties the queue, entries are kept
      cap_nxt   = cfg_cap;
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
    end else if (cmd.exec) begin
      pend_stat_nxt = STAT_OK;
      pend_pop_nxt  = 1'b0;
      case (action)
        ACT_PUSH_REAR, ACT_PUSH_FRONT: begin
          if (is_full) begin
            pend_stat_nxt = STAT_FULL;
          end else begin
            wr_en     = 1'b1;
            count_nxt = count_r + 1'b1;
            if (is_empty) begin
              // first entry lands in slot zero from either end
              head_nxt = '0;
              tail_nxt = '0;
              waddr    = '0;
            end else if (action == ACT_PUSH_REAR) begin
              tail_nxt = tail_inc;
              waddr    = tail_inc;
            end else begin
              head_nxt = head_dec;
              waddr    = head_dec;
            end
          end
        end
        ACT_POP_FRONT, ACT_POP_REAR: begin
          if (is_empty) begin
            pend_stat_nxt = STAT_EMPTY;
          end else begin
            rd_en        = 1'b1;
            pend_pop_nxt = 1'b1;
            count_nxt    = count_r - 1'b1;
            if (action == ACT_POP_FRONT) begin
              raddr    = head_r;
              head_nxt = head_inc;
            end else begin
              raddr    = tail_r;
              tail_nxt = tail_dec;
            end
            // queue drained: both indices back to slot zero
            if (last_one) begin
              head_nxt = '0;
              tail_nxt = '0;
            end
          end
        end
        default: pend_stat_nxt = STAT_OK;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      cap_r   <= CW'(DEPTH);
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      cap_r   <= cap_nxt;
    end
  end

  // entry store, registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[waddr] <= data_in;
    if (rd_en) rd_data_r <= mem[raddr];
  end

  // pending result and output register
  always_ff @(posedge clk) begin
    pend_stat_r <= pend_stat_nxt;
    pend_pop_r  <= pend_pop_nxt;
    if (cmd.load) begin
      out_data_r <= pend_pop_r ? rd_data_r : '0;
      out_stat_r <= pend_stat_r;
      out_occ_r  <= OCC_W'(count_r);
    end
  end

  assign data_out  = out_data_r;
  assign status    = out_stat_r;
  assign occupancy = out_occ_r;

endmodule

>>> rtl/core/circular_deque_unit.sv
// ----------------------------------------------------------------------------
// circular_deque_unit: double-ended queue over a circular store
// Each request pushes or pops at either end and returns one result with
// the popped value, a status and the occupancy after the operation.
// ----------------------------------------------------------------------------
// The store is a memory with a registered read port, so the popped
// value is captured in the read register when the request is taken,
// and then moves into the output register. A new request is taken
// as soon as the previous result has entered the output register, so the
// block holds one request at a time and waits while the result side
// stalls. Writing cfg_wr_data sets the capacity (0 acts as 1, above DEPTH acts
// as DEPTH) and empties the queue; stored values are not cleared. Pushes
// to a full queue and pops from an empty one change nothing and return a
// zero value with a full or empty status.
module circular_deque_unit import cdq_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ACT_W-1:0]             in_action,
  input  logic signed [DATA_WIDTH-1:0] in_data_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_data_out,
  output logic [STAT_W-1:0]            out_status,
  output logic [OCC_W-1:0]             out_occupancy,
  input  logic                         cfg_wr_en,
  input  logic [CAP_W-1:0]             cfg_wr_data
);

  cdq_cmd_t cmd;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  cdq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .action      (in_action),
    .data_in     (in_data_in),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .data_out    (out_data_out),
    .status      (out_status),
    .occupancy   (out_occupancy)
  );

  // one request in flight: the cycle after a request is taken, no other
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in flight");

  // refused requests return a zero value
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_FULL || out_status == STAT_EMPTY)
      |-> out_data_out == '0)
    else $error("refused request returned a nonzero value");

  // an empty refusal reports an empty queue
  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_EMPTY |-> out_occupancy == '0)
    else $error("empty status with nonzero occupancy");

endmodule
